[rtl/signed_alu_with_divide_unit_macros.svh]
// Assertion macros for the signed ALU checker
`ifndef SIGNED_ALU_WITH_DIVIDE_UNIT_MACROS_SVH
`define SIGNED_ALU_WITH_DIVIDE_UNIT_MACROS_SVH
`define SA_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SA_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/sad_pkg.sv]
// Package: operation and status codes, shared types
package sad_pkg;
  localparam int unsigned DATA_WIDTH_DEF = 64;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_REM = 3'd4
  } op_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_REM_ZERO = 2'd2, ST_INVALID = 2'd3
  } status_t;
endpackage

[rtl/sad_if.sv]
// Valid/ready channel interfaces for requests and results
interface sad_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface sad_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] result;
  logic [1:0]        status;
  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

[rtl/sad_mul.sv]
// Pipelined multiplier: 16-bit-digit partial products, one digit per stage
module sad_mul import sad_pkg::*; #(
  parameter int unsigned W = DATA_WIDTH_DEF,
  parameter int unsigned NS = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] p
);
  localparam int unsigned DG = 16;
  logic [W-1:0] acc_r [NS+1];
  logic [W-1:0] a_r   [NS+1];
  logic [W-1:0] b_r   [NS+1];
  always_comb begin
    acc_r[0] = '0;
    a_r[0]   = a;
    b_r[0]   = b;
  end
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DG-1:0] dig;
    logic [W+DG-1:0] pp;
    assign dig = DG'(b_r[s] >> (s*DG));
    assign pp  = {{DG{1'b0}}, a_r[s]} * {{W{1'b0}}, dig};
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s+1] <= acc_r[s] + W'(pp << (s*DG));
        a_r[s+1]   <= a_r[s];
        b_r[s+1]   <= b_r[s];
      end
    end
  end
  assign p = acc_r[NS];
endmodule

[rtl/sad_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage
module sad_div import sad_pkg::*; #(
  parameter int unsigned W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic [W-1:0] q,
  output logic [W-1:0] r
);
  logic [W-1:0] rem_r [W+1];
  logic [W-1:0] quo_r [W+1];
  logic [W-1:0] den_r [W+1];
  always_comb begin
    rem_r[0] = '0;
    quo_r[0] = n;
    den_r[0] = d;
  end
  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W:0] sh;
    logic [W:0] df;
    assign sh = {rem_r[s], quo_r[s][W-1]};
    assign df = sh - {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= df[W] ? sh[W-1:0] : df[W-1:0];
        quo_r[s+1] <= {quo_r[s][W-2:0], ~df[W]};
        den_r[s+1] <= den_r[s];
      end
    end
  end
  assign q = quo_r[W];
  assign r = rem_r[W];
endmodule

[rtl/signed_alu_with_divide_unit.sv]
// Signed ALU top level: add, subtract, multiply, divide, remainder.
// One request accepted per cycle while the output is not stalled, fully pipelined;
// the depth is set by the divider's one-bit-per-stage array. A stall freezes every stage;
// the output register accepts a new result as soon as the old one is taken.
module signed_alu_with_divide_unit import sad_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  sad_req_if.sink   in_ch,
  sad_rsp_if.source out_ch
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned MS = (W + 15) / 16;
  localparam int unsigned L = W + 1;
  logic en;
  logic [L-1:0] vld_r;
  logic [2:0] kind_r [L];
  logic [W-1:0] sum_r [L];
  logic negq_r [L];
  logic nega_r [L];
  logic bz_r [L];

  assign en = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = en;

  logic [W-1:0] a_w, b_w, ma, mb, prod, quo, rmd;
  assign a_w = in_ch.operand_a[W-1:0];
  assign b_w = in_ch.operand_b[W-1:0];
  assign ma = a_w[W-1] ? W'(-a_w) : a_w;
  assign mb = b_w[W-1] ? W'(-b_w) : b_w;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[L-2:0], in_ch.valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kind_r[0] <= in_ch.kind;
      sum_r[0]  <= (in_ch.kind == OP_SUB) ? W'(a_w - b_w) : W'(a_w + b_w);
      negq_r[0] <= a_w[W-1] ^ b_w[W-1];
      nega_r[0] <= a_w[W-1];
      bz_r[0]   <= (b_w == '0);
      for (int i = 1; i < L; i++) begin
        kind_r[i] <= kind_r[i-1];
        sum_r[i]  <= sum_r[i-1];
        negq_r[i] <= negq_r[i-1];
        nega_r[i] <= nega_r[i-1];
        bz_r[i]   <= bz_r[i-1];
      end
    end
  end

  logic [W-1:0] ma_r, mb_r, pa_r, pb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= ma; mb_r <= mb; pa_r <= a_w; pb_r <= b_w;
    end
  end

  sad_div #(.W(W)) u_div (.clk(clk), .en(en), .n(ma_r), .d(mb_r), .q(quo), .r(rmd));

  logic [W-1:0] md_r [MS+1:L-1];
  sad_mul #(.W(W), .NS(MS)) u_mul (.clk(clk), .en(en), .a(pa_r), .b(pb_r), .p(prod));
  // align product (ready at stage MS) to stage L-1
  always_ff @(posedge clk) begin
    if (en) begin
      md_r[MS+1] <= prod;
      for (int i = MS + 2; i < L; i++) md_r[i] <= md_r[i-1];
    end
  end

  logic [W-1:0] res_w;
  logic [1:0] st_w;
  logic [2:0] k;
  assign k = kind_r[L-1];
  always_comb begin
    res_w = '0;
    st_w = ST_OK;
    case (k)
      OP_ADD, OP_SUB: res_w = sum_r[L-1];
      OP_MUL: res_w = md_r[L-1];
      OP_DIV: begin
        if (bz_r[L-1]) st_w = ST_DIV_ZERO;
        else res_w = negq_r[L-1] ? W'(-quo) : quo;
      end
      OP_REM: begin
        if (bz_r[L-1]) st_w = ST_REM_ZERO;
        else res_w = nega_r[L-1] ? W'(-rmd) : rmd;
      end
      default: st_w = ST_INVALID;
    endcase
  end

  logic out_v_r;
  logic [63:0] res_r;
  logic [1:0] st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= vld_r[L-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= 64'(signed'(res_w));
      st_r  <= st_w;
    end
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.result = res_r;
  assign out_ch.status = st_r;
endmodule

[rtl/sad_checker.sv]
// Port-level checker for the signed ALU, bound to the top level
`include "signed_alu_with_divide_unit_macros.svh"
module sad_checker import sad_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [63:0] out_result,
  input logic [1:0] out_status
);
  `SA_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK, out_result == 64'sd0, "nonzero result on error")
  `SA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result), "result dropped under stall")
  `SA_ASSERT_IMPL(a_rdy, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
endmodule

bind signed_alu_with_divide_unit sad_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result), .out_status(out_ch.status)
);

[dv/tb_signed_alu_with_divide_unit.sv]
// Testbench for the signed ALU: random and corner requests checked against a predictor
class alu_scoreboard;
  typedef struct {
    logic signed [63:0] result;
    sad_pkg::status_t   status;
  } alu_result_t;

  alu_result_t pending[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  static function alu_result_t compute(logic [2:0] kind, logic signed [63:0] a,
                                       logic signed [63:0] b);
    alu_result_t r;
    logic [63:0] q, ma, mb;
    r.result = '0;
    r.status = sad_pkg::ST_OK;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    case (kind)
      sad_pkg::OP_ADD: r.result = a + b;
      sad_pkg::OP_SUB: r.result = a - b;
      sad_pkg::OP_MUL: r.result = a * b;
      sad_pkg::OP_DIV: begin
        if (b == 0) r.status = sad_pkg::ST_DIV_ZERO;
        else begin
          q = ma / mb;
          r.result = (a[63] != b[63]) ? -q : q;
        end
      end
      sad_pkg::OP_REM: begin
        if (b == 0) r.status = sad_pkg::ST_REM_ZERO;
        else begin
          q = ma % mb;
          r.result = a[63] ? -q : q;
        end
      end
      default: r.status = sad_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function void note_request(logic [2:0] kind, logic signed [63:0] a, logic signed [63:0] b);
    pending.push_back(compute(kind, a, b));
  endfunction

  function void check_result(logic signed [63:0] result, logic [1:0] status);
    alu_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h status %0d", $time, result, status);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (result !== e.result) begin
      $display("%0t: result expected %h actual %h", $time, e.result, result);
      errors++;
    end
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      errors++;
    end
  endfunction
endclass

module tb_signed_alu_with_divide_unit;
  import sad_pkg::*;

  localparam logic signed [63:0] MIN_V = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX_V = 64'sh7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 50;
  alu_scoreboard sb = new();

  sad_req_if in_ch();
  sad_rsp_if out_ch();

  signed_alu_with_divide_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result, out_ch.status);
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(logic [2:0] kind, logic signed [63:0] a, logic signed [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(kind, a, b);
  endtask

  function automatic logic signed [63:0] pick_operand();
    case ($urandom_range(7))
      0: return MIN_V;
      1: return MAX_V;
      2: return 64'(signed'($urandom_range(6))) - 3;
      3: return 64'(signed'($urandom_range(2000))) - 1000;
      4: return {$urandom, $urandom} >>> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_random(int n);
    logic [2:0] kind;
    repeat (n) begin
      kind = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_request(kind, pick_operand(), pick_operand());
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(OP_ADD, MAX_V, 64'sd1);
    send_request(OP_ADD, MIN_V, -64'sd1);
    send_request(OP_SUB, MIN_V, 64'sd1);
    send_request(OP_SUB, 64'sd0, MIN_V);
    send_request(OP_MUL, MAX_V, MAX_V);
    send_request(OP_MUL, MIN_V, -64'sd1);
    send_request(OP_MUL, -64'sd1, -64'sd1);
    send_request(OP_DIV, MIN_V, -64'sd1);
    send_request(OP_DIV, 64'sd7, -64'sd2);
    send_request(OP_DIV, -64'sd7, 64'sd2);
    send_request(OP_DIV, MAX_V, 64'sd0);
    send_request(OP_DIV, MIN_V, MIN_V);
    send_request(OP_DIV, MAX_V, MIN_V);
    send_request(OP_REM, MIN_V, -64'sd1);
    send_request(OP_REM, -64'sd7, 64'sd2);
    send_request(OP_REM, 64'sd7, -64'sd2);
    send_request(OP_REM, MIN_V, 64'sd0);
    send_request(OP_REM, MIN_V, MAX_V);
    send_request(3'd5, MAX_V, MIN_V);
    send_request(3'd6, 64'sd0, 64'sd0);
    send_request(3'd7, -64'sd1, -64'sd1);
    run_random(500);
    drain();
    send_idle_pct = 50;
    recv_idle_pct = 17;
    run_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(530);
    drain();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/sad_pkg.sv
rtl/sad_if.sv
rtl/sad_mul.sv
rtl/sad_div.sv
rtl/signed_alu_with_divide_unit.sv
rtl/sad_checker.sv
dv/tb_signed_alu_with_divide_unit.sv
